[rtl/rgbma_pkg.sv]
// ----------------------------------------------------------------------------
// RGB moving average package
// Shared widths, defaults and the sequencer state type.
// ----------------------------------------------------------------------------
package rgbma_pkg;

   // Width of one color channel sample and of one channel mean.
   localparam int CHAN_W = 8;

   // Width of the window length register as seen on the configuration port.
   localparam int WLEN_W = 7;

   // Number of color channels handled side by side.
   localparam int NUM_CHAN = 3;

   // Default depth of the sample store.
   localparam int MAX_WINDOW_DEF = 64;

   // Sequencer states of the top level.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE
   } rgbma_state_type;

endpackage

[rtl/rgbma_div.sv]
// ----------------------------------------------------------------------------
// RGB moving average divider
// Restoring divider with one lane per color channel. All lanes share one
// divisor and one sequencer and retire one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rgbma_div
   import rgbma_pkg::*;
#(
   parameter int SUM_W = 14,
   parameter int LEN_W = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [LEN_W-1:0]  divisor,
   input  logic [SUM_W-1:0]  dividend [NUM_CHAN],
   output logic              done,
   output logic [CHAN_W-1:0] quotient [NUM_CHAN]
);

   localparam int CNT_W = (CHAN_W > 1) ? $clog2(CHAN_W) : 1;

   logic [SUM_W-1:0]  rem_ff [NUM_CHAN];
   logic [SUM_W-1:0]  rem_in [NUM_CHAN];
   logic [CHAN_W-1:0] quo_ff [NUM_CHAN];
   logic [CHAN_W-1:0] quo_in [NUM_CHAN];
   logic [SUM_W-1:0]  dsh_ff;
   logic [SUM_W-1:0]  dsh_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic              busy_ff;
   logic              busy_in;
   logic              done_ff;
   logic              done_in;

   // One compare and subtract per lane against the shifted divisor.
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsh_in  = dsh_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = dividend;
         for (int k = 0; k < NUM_CHAN; k++) begin
            quo_in[k] = '0;
         end
         dsh_in  = SUM_W'(divisor) << (CHAN_W - 1);
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         for (int k = 0; k < NUM_CHAN; k++) begin
            if (rem_ff[k] >= dsh_ff) begin
               rem_in[k] = rem_ff[k] - dsh_ff;
               quo_in[k] = {quo_ff[k][CHAN_W-2:0], 1'b1};
            end else begin
               quo_in[k] = {quo_ff[k][CHAN_W-2:0], 1'b0};
            end
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(CHAN_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsh_ff <= dsh_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/rgb_moving_average.sv]
// ----------------------------------------------------------------------------
// RGB moving average
// Per-channel moving average of RGB samples over a programmable window.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one color sample per transaction (valid/stall).
//   Each sample replaces the oldest slot of a ring store of window_length
//   slots, and the rsp channel returns the truncated mean of each channel
//   over all slots; slots not yet written count as zero.
//   The csr channel (valid/ready) writes window_length; values are clamped
//   to 1..MAX_WINDOW, and a changed value empties the window. It is taken
//   only while no sample is in progress.
//   A sample passes through the store read and sum update, then the
//   bit-serial divider, and then the load of the output register that
//   raises rsp_valid. The sequencer returns to idle as the result loads
//   and only then takes the next sample, so the divider sets the rate.
//   The output register holds a finished result while rsp_stall is high;
//   a following result then waits in the divider.
//   Reset empties the window, sets window_length to 1 and drops any pending
//   result. The store itself is not swept: a wrap flag marks which slots
//   hold data since the window was last emptied.
// ----------------------------------------------------------------------------
module rgb_moving_average
   import rgbma_pkg::*;
#(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // Sample input
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CHAN_W-1:0] req_red,
   input  logic [CHAN_W-1:0] req_green,
   input  logic [CHAN_W-1:0] req_blue,
   // Mean output
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CHAN_W-1:0] rsp_avg_red,
   output logic [CHAN_W-1:0] rsp_avg_green,
   output logic [CHAN_W-1:0] rsp_avg_blue,
   // Window length register
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [WLEN_W-1:0] csr_window_length
);

   localparam int POS_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int WIN_W = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W = $clog2(MAX_WINDOW * ((1 << CHAN_W) - 1) + 1);
   localparam int SMP_W = NUM_CHAN * CHAN_W;

   rgbma_state_type   state_ff;
   rgbma_state_type   state_in;
   logic [POS_W-1:0]  pos_ff;
   logic [POS_W-1:0]  pos_in;
   logic              wrap_ff;
   logic              wrap_in;
   logic [WIN_W-1:0]  win_ff;
   logic [WIN_W-1:0]  win_in;
   logic [SUM_W-1:0]  sum_ff [NUM_CHAN];
   logic [SUM_W-1:0]  sum_in [NUM_CHAN];
   logic [SMP_W-1:0]  smp_ff;
   logic [SMP_W-1:0]  rd_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [CHAN_W-1:0] avg_ff [NUM_CHAN];

   logic [SMP_W-1:0]  mem [MAX_WINDOW];

   logic              req_accept;
   logic              csr_write;
   logic              rsp_load;
   logic              div_start;
   logic              div_done;
   logic [CHAN_W-1:0] div_quo [NUM_CHAN];
   logic [WIN_W-1:0]  csr_len;
   logic [WIN_W-1:0]  pos_inc;
   logic [CHAN_W-1:0] old_chan;

   assign req_stall  = (state_ff != ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_write  = csr_valid && csr_ready;

   // Clamp the written window length into 1..MAX_WINDOW.
   always_comb begin
      if (csr_window_length == '0) begin
         csr_len = WIN_W'(1);
      end else if (32'(csr_window_length) > 32'(MAX_WINDOW)) begin
         csr_len = WIN_W'(MAX_WINDOW);
      end else begin
         csr_len = WIN_W'(csr_window_length);
      end
   end

   // Sequencer: next state, sum update and window bookkeeping.
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      wrap_in      = wrap_ff;
      win_in       = win_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_load     = 1'b0;
      div_start    = 1'b0;
      old_chan     = '0;
      pos_inc      = WIN_W'(pos_ff) + WIN_W'(1);

      // The output register empties when its transaction completes.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // Swap the oldest slot for the new sample in each running sum.
            for (int k = 0; k < NUM_CHAN; k++) begin
               old_chan  = wrap_ff ? rd_ff[k*CHAN_W +: CHAN_W] : '0;
               sum_in[k] = sum_ff[k] - SUM_W'(old_chan)
                         + SUM_W'(smp_ff[k*CHAN_W +: CHAN_W]);
            end
            if (pos_inc >= win_ff) begin
               pos_in  = '0;
               wrap_in = 1'b1;
            end else begin
               pos_in = POS_W'(pos_inc);
            end
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done && (!rsp_valid_ff || !rsp_stall)) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A changed window length empties the window.
      if (csr_write && (csr_len != win_ff)) begin
         win_in  = csr_len;
         pos_in  = '0;
         wrap_in = 1'b0;
         for (int k = 0; k < NUM_CHAN; k++) begin
            sum_in[k] = '0;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         wrap_ff      <= 1'b0;
         win_ff       <= WIN_W'(1);
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_CHAN; k++) begin
            sum_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         wrap_ff      <= wrap_in;
         win_ff       <= win_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
      end
   end

   // Sample capture and output register.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         smp_ff <= {req_blue, req_green, req_red};
      end
      if (rsp_load) begin
         avg_ff <= div_quo;
      end
   end

   // Sample store: read the oldest slot on acceptance, overwrite it next cycle.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_ff <= mem[pos_ff];
      end
      if (state_ff == ST_UPDATE) begin
         mem[pos_ff] <= smp_ff;
      end
   end

   // Shared bit-serial divider for the three channel means.
   rgbma_div #(
      .SUM_W (SUM_W),
      .LEN_W (WIN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (win_ff),
      .dividend (sum_in),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_avg_red   = avg_ff[0];
   assign rsp_avg_green = avg_ff[1];
   assign rsp_avg_blue  = avg_ff[2];

endmodule

[bench/rgb_moving_average_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB moving average checker
// Watches the sample, mean and window length channels, keeps its own copy of
// the sample window, predicts the mean for each sample transaction and
// compares it, channel by channel, with the next mean transaction.
// ----------------------------------------------------------------------------
module rgb_moving_average_checker
   import rgbma_pkg::*;
#(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [CHAN_W-1:0] req_red,
   input  logic [CHAN_W-1:0] req_green,
   input  logic [CHAN_W-1:0] req_blue,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [CHAN_W-1:0] rsp_avg_red,
   input  logic [CHAN_W-1:0] rsp_avg_green,
   input  logic [CHAN_W-1:0] rsp_avg_blue,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [WLEN_W-1:0] csr_window_length,
   output int                error_count,
   output int                pending_count
);

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_color_type;

   // Shadow of the window: slots, next slot, running channel sums, length.
   rgb_color_type color_ring [MAX_WINDOW];
   int unsigned   ring_pos;
   int unsigned   window_len;
   logic [13:0]   sum_red;
   logic [13:0]   sum_green;
   logic [13:0]   sum_blue;

   // Means predicted for samples whose result has not come out yet.
   rgb_color_type expected_means [$];
   int            errors;

   // Length as the block applies it: saturated to 1..MAX_WINDOW.
   function automatic int unsigned clamp_window(logic [WLEN_W-1:0] value);
      if (value == 0)
         return 1;
      if (value > MAX_WINDOW)
         return MAX_WINDOW;
      return 32'(value);
   endfunction

   task automatic empty_window();
      for (int i = 0; i < MAX_WINDOW; i++) begin
         color_ring[i] = '0;
      end
      ring_pos  = 0;
      sum_red   = '0;
      sum_green = '0;
      sum_blue  = '0;
   endtask

   // Replaces the oldest slot with the new sample and returns the window mean.
   task automatic predict_mean(input rgb_color_type sample, output rgb_color_type mean);
      int unsigned slot;
      slot = (ring_pos >= window_len) ? 0 : ring_pos;
      sum_red   = sum_red   - color_ring[slot].red   + sample.red;
      sum_green = sum_green - color_ring[slot].green + sample.green;
      sum_blue  = sum_blue  - color_ring[slot].blue  + sample.blue;
      color_ring[slot] = sample;
      ring_pos = (slot + 1 >= window_len) ? 0 : slot + 1;
      mean.red   = CHAN_W'(sum_red   / window_len);
      mean.green = CHAN_W'(sum_green / window_len);
      mean.blue  = CHAN_W'(sum_blue  / window_len);
   endtask

   always @(posedge clock) begin : monitor
      rgb_color_type got;
      rgb_color_type want;
      int unsigned   new_len;
      if (reset) begin
         empty_window();
         window_len = 1;
         expected_means.delete();
         errors = 0;
      end else begin
         // A changed length empties the window; the same length does nothing.
         if (csr_valid && csr_ready) begin
            new_len = clamp_window(csr_window_length);
            if (new_len != window_len) begin
               window_len = new_len;
               empty_window();
            end
         end

         // Compare a finished mean transaction with the oldest prediction.
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_avg_red, rsp_avg_green, rsp_avg_blue};
            if (expected_means.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("unexpected mean transaction: r=%0d g=%0d b=%0d",
                           got.red, got.green, got.blue);
            end else begin
               want = expected_means.pop_front();
               if (got.red !== want.red || got.green !== want.green ||
                   got.blue !== want.blue) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display({"mean mismatch: expected r=%0d g=%0d b=%0d, ",
                               "got r=%0d g=%0d b=%0d"},
                              want.red, want.green, want.blue,
                              got.red, got.green, got.blue);
               end
            end
         end

         // Every accepted sample transaction yields exactly one mean.
         if (req_valid && !req_stall) begin
            predict_mean({req_red, req_green, req_blue}, want);
            expected_means = {expected_means, want};
         end
      end
      pending_count <= expected_means.size();
      error_count   <= errors;
   end

endmodule

[bench/rgb_moving_average_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB moving average testbench
// Drives color samples and window length writes into the block, with phases
// of random sender gaps and receiver stalls, and lets the checker predict and
// compare every mean. Prints the verdict once all means have come out.
// ----------------------------------------------------------------------------
module rgb_moving_average_tb;
   import rgbma_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 12;
   localparam int NUM_PHASES = 8;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [CHAN_W-1:0] req_red = '0;
   logic [CHAN_W-1:0] req_green = '0;
   logic [CHAN_W-1:0] req_blue = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [CHAN_W-1:0] rsp_avg_red;
   logic [CHAN_W-1:0] rsp_avg_green;
   logic [CHAN_W-1:0] rsp_avg_blue;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [WLEN_W-1:0] csr_window_length = '0;

   int error_count;
   int pending_count;
   int quiet_cycles = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   rgb_moving_average u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_avg_red       (rsp_avg_red),
      .rsp_avg_green     (rsp_avg_green),
      .rsp_avg_blue      (rsp_avg_blue),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_window_length (csr_window_length)
   );

   rgb_moving_average_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_avg_red       (rsp_avg_red),
      .rsp_avg_green     (rsp_avg_green),
      .rsp_avg_blue      (rsp_avg_blue),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_window_length (csr_window_length),
      .error_count       (error_count),
      .pending_count     (pending_count)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver back-pressure at the rate of the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Watchdog: too long without any transaction on any channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[rgb_moving_average] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Channel value biased toward the extremes.
   function automatic logic [CHAN_W-1:0] random_level();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return CHAN_W'($urandom);
      endcase
   endfunction

   // One sample transaction, with random sender gaps ahead of it. Valid stays
   // high after acceptance so that back-to-back samples need no bubble.
   task automatic send_color(input logic [CHAN_W-1:0] red, input logic [CHAN_W-1:0] green,
                             input logic [CHAN_W-1:0] blue);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= red;
      req_green <= green;
      req_blue  <= blue;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop sending, wait for every predicted mean and let the block settle.
   task automatic drain_means();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Window length write, issued only with the block idle.
   task automatic write_window_length(input logic [WLEN_W-1:0] value);
      drain_means();
      csr_valid         <= 1'b1;
      csr_window_length <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int phase_windows [NUM_PHASES];
      int phase_items;
      phase_windows = '{64, 1, 2, 5, 16, 64, 33, 7};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Length zero saturates to one, the reset value, so the window is kept.
      write_window_length(0);
      send_color(8'd0, 8'd0, 8'd0);
      send_color(8'd255, 8'd255, 8'd255);
      send_color(8'd255, 8'd0, 8'd128);
      send_color(8'd1, 8'd2, 8'd3);

      // All-ones length saturates to the deepest window; empty slots count.
      write_window_length('1);
      send_color(8'd255, 8'd255, 8'd255);
      send_color(8'd255, 8'd255, 8'd255);
      send_color(8'd255, 8'd255, 8'd255);
      send_color(8'd0, 8'd0, 8'd0);

      // A different raw value with the same saturated length changes nothing.
      write_window_length(100);
      send_color(8'd255, 8'd255, 8'd255);
      send_color(8'd255, 8'd255, 8'd255);

      // Short window: the ring wraps and overwrites the oldest samples.
      write_window_length(3);
      send_color(8'd255, 8'd255, 8'd255);
      send_color(8'd254, 8'd1, 8'd128);
      send_color(8'd7, 8'd8, 8'd9);
      send_color(8'd255, 8'd255, 8'd255);
      send_color(8'd0, 8'd255, 8'd0);

      // Random phases: each sets a length and one gap/stall pattern.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         write_window_length(WLEN_W'(phase_windows[phase]));
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 50; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 50; end
            default: begin send_idle_pct = 11; stall_pct = 11; end
         endcase
         phase_items = (phase_windows[phase] == 64) ? 80 : 50;
         for (int i = 0; i < phase_items; i++) begin
            send_color(random_level(), random_level(), random_level());
         end
      end

      drain_means();
      if (error_count == 0 && pending_count == 0) begin
         $display("[rgb_moving_average] OK");
      end else begin
         $display("[rgb_moving_average] ERROR");
      end
      $finish;
   end

endmodule
